// ===== hw/rtl/bpmdos_pkg.sv =====
// Shared types, constants and helpers of the beam position difference-over-sum unit.
package bpmdos_pkg;

  localparam int unsigned RawW       = 13;
  localparam int unsigned AdcBitsDef = 13;
  localparam int unsigned PedW       = 16;
  localparam int unsigned CfgW       = 64;
  localparam int unsigned PosW       = 24;
  localparam int unsigned GainW      = 20;
  localparam int unsigned RatioW     = 18;
  localparam int unsigned MatW       = 16;
  localparam int unsigned DivN       = 18;
  // Lane pipeline: sample stage, magnitude stage, DivN quotient stages,
  // saturation, multiply and rounding.
  localparam int unsigned LaneLat    = DivN + 5;
  localparam int unsigned MergeLat   = 2;
  localparam int unsigned TotalLat   = LaneLat + MergeLat;

  localparam logic [CfgW-1:0] RotReset = 64'h4000_0000_0000_4000;

  typedef enum logic [2:0] {
    REG_PEDESTAL = 3'd0,
    REG_ROTATION = 3'd1,
    REG_GAIN     = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_Z_POS    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic vld;
    logic all;
  } beat_tag_t;

  function automatic logic signed [PosW-1:0] sat24(input logic signed [27:0] x);
    logic signed [27:0] hi;
    logic signed [27:0] lo;
    hi = 28'sd8388607;
    lo = -28'sd8388608;
    if (x > hi) begin
      sat24 = hi[PosW-1:0];
    end else if (x < lo) begin
      sat24 = lo[PosW-1:0];
    end else begin
      sat24 = x[PosW-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/beam_position_diff_over_sum_unit.sv =====
// Top level of the beam position difference-over-sum unit.
//
// Input beats are four ADC samples and a presence mask, taken at each rising
// edge where start is high and busy is low. busy stays low, so a new
// beat may enter every cycle; throughput is one beat per cycle.
// Two lanes, one per antenna pair, each run an 18-stage restoring divider
// that retires one quotient bit per stage, then gain scaling. A merging
// stage applies the rotation matrix and the offsets.
// Each result passes the lane pipeline and then the product and output
// registers of the merging stage.
// Each result is shown for one cycle with valid_o high; the receiver cannot
// stall, and results leave in beat order.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i and
// must only change while no beat is in flight. pos_z_o follows z_q.
// Reset clears the pipeline valid flags and loads the register defaults:
// identity rotation, zero pedestals, gain and offsets.
module beam_position_diff_over_sum_unit
  import bpmdos_pkg::*;
#(
  parameter int unsigned ADC_BITS = AdcBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [RawW-1:0]        raw_a_i,
  input  logic [RawW-1:0]        raw_b_i,
  input  logic [RawW-1:0]        raw_c_i,
  input  logic [RawW-1:0]        raw_d_i,
  input  logic [3:0]             present_mask_i,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [CfgW-1:0]        cfg_wdata_i,
  output logic                   valid_o,
  output logic                   all_fired_o,
  output logic signed [PosW-1:0] rot_u_o,
  output logic signed [PosW-1:0] rot_v_o,
  output logic signed [PosW-1:0] pos_x_o,
  output logic signed [PosW-1:0] pos_y_o,
  output logic signed [PosW-1:0] pos_z_o
);

  logic [CfgW-1:0] ped_q, rot_q;
  logic signed [GainW-1:0] gain_q;
  logic signed [PosW-1:0] off_x_q, off_y_q, z_q;
  beat_tag_t tag_q [0:LaneLat-1];
  beat_tag_t tag_out;
  logic signed [PosW-1:0] u_lane, v_lane;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ped_q   <= '0;
      rot_q   <= RotReset;
      gain_q  <= '0;
      off_x_q <= '0;
      off_y_q <= '0;
      z_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PEDESTAL: ped_q   <= cfg_wdata_i;
        REG_ROTATION: rot_q   <= cfg_wdata_i;
        REG_GAIN:     gain_q  <= cfg_wdata_i[GainW-1:0];
        REG_OFFSET_X: off_x_q <= cfg_wdata_i[PosW-1:0];
        REG_OFFSET_Y: off_y_q <= cfg_wdata_i[PosW-1:0];
        REG_Z_POS:    z_q     <= cfg_wdata_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LaneLat; i++) begin
        tag_q[i] <= '0;
      end
    end else begin
      tag_q[0].vld <= start && !busy;
      tag_q[0].all <= (present_mask_i == 4'hF);
      for (int i = 1; i < LaneLat; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  bpmdos_lane #(.ADC_BITS(ADC_BITS)) u_lane_ab (
    .clk_i   (clk_i),
    .raw_p_i (raw_a_i),
    .raw_q_i (raw_b_i),
    .ped_p_i (ped_q[15:0]),
    .ped_q_i (ped_q[31:16]),
    .gain_i  (gain_q),
    .pos_o   (u_lane)
  );

  bpmdos_lane #(.ADC_BITS(ADC_BITS)) u_lane_cd (
    .clk_i   (clk_i),
    .raw_p_i (raw_c_i),
    .raw_q_i (raw_d_i),
    .ped_p_i (ped_q[47:32]),
    .ped_q_i (ped_q[63:48]),
    .gain_i  (gain_q),
    .pos_o   (v_lane)
  );

  bpmdos_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag_q[LaneLat-1]),
    .u_i     (u_lane),
    .v_i     (v_lane),
    .rot_i   (rot_q),
    .off_x_i (off_x_q),
    .off_y_i (off_y_q),
    .tag_o   (tag_out),
    .u_o     (rot_u_o),
    .v_o     (rot_v_o),
    .x_o     (pos_x_o),
    .y_o     (pos_y_o)
  );

  assign valid_o     = tag_out.vld;
  assign all_fired_o = tag_out.all;
  assign pos_z_o     = z_q;

  a_no_fire_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !all_fired_o) |-> (rot_u_o == '0 && rot_v_o == '0))
    else $error("missing channel gave a nonzero pair position");

  a_strobe_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(tag_q[0].vld, TotalLat - 1))
    else $error("result strobe without an accepted beat");

  a_accept_to_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_q[LaneLat-1].vld |-> ##2 valid_o)
    else $error("beat lost in the merging stage");

endmodule

// ===== hw/rtl/bpmdos_lane.sv =====
// One antenna-pair lane: pedestal removal, pipelined ratio divider and gain scaling.
module bpmdos_lane
  import bpmdos_pkg::*;
#(
  parameter int unsigned ADC_BITS = AdcBitsDef
) (
  input  logic                    clk_i,
  input  logic [RawW-1:0]         raw_p_i,
  input  logic [RawW-1:0]         raw_q_i,
  input  logic [PedW-1:0]         ped_p_i,
  input  logic [PedW-1:0]         ped_q_i,
  input  logic signed [GainW-1:0] gain_i,
  output logic signed [PosW-1:0]  pos_o
);

  localparam int unsigned UseW = (ADC_BITS < RawW) ? ADC_BITS : RawW;

  logic signed [17:0] cor_p, cor_q;
  logic signed [18:0] diff_q, sum_q;
  logic [18:0] mag_n, mag_d;

  logic [32:0]       rem_q  [0:DivN];
  logic [RatioW-1:0] den_q  [0:DivN];
  logic [DivN-1:0]   quo_q  [0:DivN];
  logic              neg_q  [0:DivN];
  logic              zero_q [0:DivN];
  logic              ovf_q  [0:DivN];

  logic signed [RatioW-1:0] ratio_q;
  logic signed [37:0] prod_q;
  logic signed [38:0] rnd;
  logic signed [PosW-1:0] pos_q;

  assign cor_p = $signed(18'(raw_p_i[UseW-1:0])) - $signed({2'b0, ped_p_i});
  assign cor_q = $signed(18'(raw_q_i[UseW-1:0])) - $signed({2'b0, ped_q_i});

  always_ff @(posedge clk_i) begin
    diff_q <= 19'(cor_p) - 19'(cor_q);
    sum_q  <= 19'(cor_p) + 19'(cor_q);
  end

  assign mag_n = diff_q[18] ? 19'(-diff_q) : diff_q;
  assign mag_d = sum_q[18]  ? 19'(-sum_q)  : sum_q;

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= {mag_n[17:0], 15'b0};
    den_q[0]  <= mag_d[17:0];
    quo_q[0]  <= '0;
    neg_q[0]  <= diff_q[18] ^ sum_q[18];
    zero_q[0] <= (sum_q == '0);
    // A quotient of DivN bits or more saturates anyway.
    ovf_q[0]  <= {3'b0, mag_n[17:0], 15'b0} >= {mag_d[17:0], 18'b0};
  end

  for (genvar j = 0; j < DivN; j++) begin : g_div
    logic signed [35:0] trial;
    assign trial = $signed({3'b0, rem_q[j]})
                 - $signed(36'(den_q[j]) << (DivN - 1 - j));
    always_ff @(posedge clk_i) begin
      rem_q[j+1]  <= trial[35] ? rem_q[j] : trial[32:0];
      quo_q[j+1]  <= {quo_q[j][DivN-2:0], ~trial[35]};
      den_q[j+1]  <= den_q[j];
      neg_q[j+1]  <= neg_q[j];
      zero_q[j+1] <= zero_q[j];
      ovf_q[j+1]  <= ovf_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (zero_q[DivN]) begin
      ratio_q <= '0;
    end else if (!neg_q[DivN]) begin
      ratio_q <= (ovf_q[DivN] || quo_q[DivN][DivN-1]) ? 18'sd131071
                                                      : $signed(quo_q[DivN]);
    end else begin
      ratio_q <= (ovf_q[DivN] || (quo_q[DivN] > 18'd131072)) ? -18'sd131072
                                                             : 18'(-quo_q[DivN]);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= gain_i * ratio_q;
  end

  // The scaled value stays within 2^21, so the 24-bit slice needs no clamp.
  assign rnd = {prod_q[37], prod_q} + 39'sd16384;

  always_ff @(posedge clk_i) begin
    pos_q <= rnd[38:15];
  end

  assign pos_o = pos_q;

endmodule

// ===== hw/rtl/bpmdos_merge.sv =====
// Merging stage: gates the lane results, rotates them and adds the offsets.
module bpmdos_merge
  import bpmdos_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  beat_tag_t              tag_i,
  input  logic signed [PosW-1:0] u_i,
  input  logic signed [PosW-1:0] v_i,
  input  logic [CfgW-1:0]        rot_i,
  input  logic signed [PosW-1:0] off_x_i,
  input  logic signed [PosW-1:0] off_y_i,
  output beat_tag_t              tag_o,
  output logic signed [PosW-1:0] u_o,
  output logic signed [PosW-1:0] v_o,
  output logic signed [PosW-1:0] x_o,
  output logic signed [PosW-1:0] y_o
);

  logic signed [PosW-1:0] ug, vg;
  logic signed [PosW-1:0] u_q, v_q, uo_q, vo_q, x_q, y_q;
  logic signed [39:0] p00_q, p01_q, p10_q, p11_q;
  logic signed [40:0] sx, sy, rx, ry;
  beat_tag_t tag1_q, tag2_q;

  assign ug = tag_i.all ? u_i : '0;
  assign vg = tag_i.all ? v_i : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q   <= ug;
    v_q   <= vg;
    p00_q <= $signed(rot_i[15:0])  * ug;
    p01_q <= $signed(rot_i[31:16]) * vg;
    p10_q <= $signed(rot_i[47:32]) * ug;
    p11_q <= $signed(rot_i[63:48]) * vg;
  end

  assign sx = 41'(p00_q) + 41'(p01_q) + 41'sd8192;
  assign sy = 41'(p10_q) + 41'(p11_q) + 41'sd8192;
  assign rx = sx >>> 14;
  assign ry = sy >>> 14;

  // The rotated value stays well inside 28 bits, so the signed cast keeps its sign.
  always_ff @(posedge clk_i) begin
    uo_q <= u_q;
    vo_q <= v_q;
    x_q  <= sat24(28'(rx) + 28'(off_x_i));
    y_q  <= sat24(28'(ry) + 28'(off_y_i));
  end

  assign tag_o = tag2_q;
  assign u_o   = uo_q;
  assign v_o   = vo_q;
  assign x_o   = x_q;
  assign y_o   = y_q;

endmodule
